@@ hdl/cfra_pkg.sv @@
package cfra_pkg;

   localparam int RATIO_W    = 32;
   localparam int NUM_W      = 48;
   localparam int DEN_W      = 10;
   localparam int P_W        = 48;
   localparam int A_W        = 14;
   localparam int REM_W      = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DIV_STEPS  = 64;
   localparam int DIV_CNT_W  = 6;
   localparam int ERR_W      = 20;
   localparam int TOL_W      = 14;
   localparam int ERR_TOL    = 10000;
   localparam int A_MAX_BND  = 10000;

   localparam logic [REM_W-1:0] EPS_Q32 = 32'd429497;

   localparam int DEF_MAX_TERMS  = 24;
   localparam int DEF_TERM_LIMIT = 1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_MUL,
      ST_CHK_ERR,
      ST_CHK_DEC,
      ST_DIV,
      ST_MUL,
      ST_UPD,
      ST_FIN,
      ST_CMP_L,
      ST_CMP_R
   } state_type;

   typedef enum logic [1:0] {
      ASPECT_SQUARE    = 2'd0,
      ASPECT_LANDSCAPE = 2'd1,
      ASPECT_PORTRAIT  = 2'd2
   } aspect_type;

   typedef struct packed {
      logic load;
      logic chk_mul;
      logic chk_err;
      logic div_init;
      logic div_step;
      logic mul;
      logic upd;
      logic fin_sel;
      logic cmp_l;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic stop_hit;
   } status_type;

endpackage

@@ hdl/cfra_ctrl.sv @@
module cfra_ctrl #(
   parameter int MAX_TERMS = cfra_pkg::DEF_MAX_TERMS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cfra_pkg::status_type   status,
   output cfra_pkg::cmd_type      cmd
);

   localparam int TERM_CNT_W = $clog2(MAX_TERMS + 1);
   localparam logic [TERM_CNT_W-1:0] TERMS_END = TERM_CNT_W'(MAX_TERMS);
   localparam logic [cfra_pkg::DIV_CNT_W-1:0] DIV_LAST =
      cfra_pkg::DIV_CNT_W'(cfra_pkg::DIV_STEPS - 1);

   cfra_pkg::state_type state_ff, state_in;
   logic [TERM_CNT_W-1:0] terms_ff, terms_in;
   logic [cfra_pkg::DIV_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic stop;
   logic out_free;

   assign stop     = (terms_ff == TERMS_END) || status.stop_hit;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfra_pkg::ST_IDLE:    if (req_valid) state_in = cfra_pkg::ST_CHK_MUL;
         cfra_pkg::ST_CHK_MUL: state_in = cfra_pkg::ST_CHK_ERR;
         cfra_pkg::ST_CHK_ERR: state_in = cfra_pkg::ST_CHK_DEC;
         cfra_pkg::ST_CHK_DEC: state_in = stop ? cfra_pkg::ST_FIN : cfra_pkg::ST_DIV;
         cfra_pkg::ST_DIV:     if (bit_cnt_ff == DIV_LAST) state_in = cfra_pkg::ST_MUL;
         cfra_pkg::ST_MUL:     state_in = cfra_pkg::ST_UPD;
         cfra_pkg::ST_UPD:     state_in = cfra_pkg::ST_CHK_MUL;
         cfra_pkg::ST_FIN:     state_in = cfra_pkg::ST_CMP_L;
         cfra_pkg::ST_CMP_L:   state_in = cfra_pkg::ST_CMP_R;
         cfra_pkg::ST_CMP_R:   if (out_free) state_in = cfra_pkg::ST_IDLE;
         default:              state_in = cfra_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cfra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         cfra_pkg::ST_CHK_MUL: cmd.chk_mul  = 1'b1;
         cfra_pkg::ST_CHK_ERR: cmd.chk_err  = 1'b1;
         cfra_pkg::ST_CHK_DEC: cmd.div_init = !stop;
         cfra_pkg::ST_DIV:     cmd.div_step = 1'b1;
         cfra_pkg::ST_MUL:     cmd.mul      = 1'b1;
         cfra_pkg::ST_UPD:     cmd.upd      = 1'b1;
         cfra_pkg::ST_FIN:     cmd.fin_sel  = 1'b1;
         cfra_pkg::ST_CMP_L:   cmd.cmp_l    = 1'b1;
         cfra_pkg::ST_CMP_R:   cmd.commit   = out_free;
         default: ;
      endcase
   end

   always_comb begin
      terms_in = terms_ff;
      if (cmd.load) begin
         terms_in = '0;
      end else if (cmd.upd) begin
         terms_in = terms_ff + TERM_CNT_W'(1);
      end
      bit_cnt_in = bit_cnt_ff;
      if (cmd.div_init) begin
         bit_cnt_in = '0;
      end else if (cmd.div_step) begin
         bit_cnt_in = bit_cnt_ff + cfra_pkg::DIV_CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfra_pkg::ST_IDLE;
         terms_ff     <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         terms_ff     <= terms_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_terms_bound: assert property (@(posedge clock) disable iff (reset)
      terms_ff <= TERMS_END)
      else $error("term count past limit");

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfra_pkg::ST_DIV && bit_cnt_ff != DIV_LAST) |=>
      state_ff == cfra_pkg::ST_DIV)
      else $error("divider left early");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && rsp_valid_ff) |-> rsp_ready)
      else $error("pending beat overwritten");

endmodule

@@ hdl/cfra_dp.sv @@
module cfra_dp #(
   parameter int TERM_LIMIT = cfra_pkg::DEF_TERM_LIMIT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfra_pkg::cmd_type                     cmd,
   output cfra_pkg::status_type                  status,
   input  logic signed [cfra_pkg::RATIO_W-1:0]   req_ratio_in,
   output logic signed [cfra_pkg::NUM_W-1:0]     rsp_frac_numerator,
   output logic        [cfra_pkg::DEN_W-1:0]     rsp_frac_denominator,
   output logic                                  rsp_used_fallback,
   output logic                                  rsp_ratio_changed,
   output logic        [1:0]                     rsp_aspect_class
);

   localparam int P_W    = cfra_pkg::P_W;
   localparam int A_W    = cfra_pkg::A_W;
   localparam int R_W    = cfra_pkg::RATIO_W;
   localparam int F_B    = cfra_pkg::FRAC_BITS;
   localparam int N_W    = cfra_pkg::NUM_W;
   localparam int D_W    = cfra_pkg::DEN_W;
   localparam int E_W    = cfra_pkg::ERR_W;
   localparam int T_W    = cfra_pkg::TOL_W;
   localparam int Q_W    = $clog2(cfra_pkg::A_MAX_BND * TERM_LIMIT);
   localparam int LQ_W   = $clog2(TERM_LIMIT);
   localparam int PROD_W = R_W + LQ_W + 1;
   localparam int DIFF_W = P_W + F_B + 1;
   localparam int SC_W   = E_W + T_W;
   localparam int CMP_W  = N_W + D_W + 1;
   localparam int SAT_LO = N_W - F_B - 1;

   localparam logic signed [P_W-1:0] P_LIMIT = P_W'(TERM_LIMIT);
   localparam logic [Q_W-1:0] Q_LIMIT = Q_W'(TERM_LIMIT);
   localparam logic signed [N_W-1:0] NUM_MAX = {1'b0, {(N_W-1){1'b1}}};
   localparam logic signed [N_W-1:0] NUM_MIN = {1'b1, {(N_W-1){1'b0}}};
   localparam logic [N_W-1:0] ONE_Q = N_W'(1) << F_B;

   logic signed [R_W-1:0]  x_ff;
   logic signed [P_W-1:0]  p0_ff, p1_ff, ap_ff;
   logic [Q_W-1:0]         q0_ff, q1_ff, aq_ff;
   logic [cfra_pkg::REM_W-1:0] rem_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [E_W-1:0]         err_ff;
   logic                   err_big_ff;
   logic [cfra_pkg::REM_W:0] part_ff;
   logic [2*cfra_pkg::REM_W-1:0] quo_ff;
   logic signed [N_W-1:0]  num_ff;
   logic [D_W-1:0]         den_ff;
   logic                   fb_ff;
   logic signed [CMP_W-1:0] lhs_ff;
   logic signed [N_W-1:0]  st_num_ff, st_num_in;
   logic [D_W-1:0]         st_den_ff, st_den_in;
   logic                   fb_out_ff, chg_ff;
   cfra_pkg::aspect_type   aspect_ff, aspect_in;

   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]      err_abs;
   logic [SC_W-1:0]        err_scaled, err_bound;
   logic                   err_ok;
   logic [cfra_pkg::REM_W:0] part_sh, part_sub;
   logic                   qbit;
   logic [A_W-1:0]         a_term;
   logic signed [P_W+A_W:0] ap_prod;
   logic [Q_W+A_W-1:0]     aq_prod;
   logic                   p_ok, q_ok;
   logic signed [N_W-1:0]  p_num, num_sel;
   logic [D_W-1:0]         den_sel;
   logic signed [CMP_W-1:0] rhs;
   logic signed [N_W-1:0]  den_scaled;

   assign diff = $signed({p1_ff[P_W-1], p1_ff, {F_B{1'b0}}})
               - DIFF_W'(prod_ff);
   assign err_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

   assign err_scaled = SC_W'(err_ff) * SC_W'(cfra_pkg::ERR_TOL);
   assign err_bound  = SC_W'({q1_ff[LQ_W-1:0], {F_B{1'b0}}});
   assign err_ok     = !err_big_ff && (err_scaled <= err_bound);

   assign status.stop_hit = (rem_ff < cfra_pkg::EPS_Q32) || (p1_ff >= P_LIMIT)
                          || (q1_ff >= Q_LIMIT) || err_ok;

   assign part_sh  = {part_ff[cfra_pkg::REM_W-1:0], 1'b0};
   assign part_sub = part_sh - {1'b0, rem_ff};
   assign qbit     = part_sh >= {1'b0, rem_ff};
   assign a_term   = quo_ff[cfra_pkg::REM_W+A_W-1:cfra_pkg::REM_W];

   assign ap_prod = $signed({{(A_W+1){p1_ff[P_W-1]}}, p1_ff})
                  * $signed({{(P_W+1){1'b0}}, a_term});
   assign aq_prod = {{Q_W{1'b0}}, a_term} * {{A_W{1'b0}}, q1_ff};

   assign p_ok = p1_ff < P_LIMIT;
   assign q_ok = q1_ff < Q_LIMIT;

   always_comb begin
      if (!p1_ff[P_W-1] && (|p1_ff[P_W-2:SAT_LO])) begin
         p_num = NUM_MAX;
      end else if (p1_ff[P_W-1] && !(&p1_ff[P_W-2:SAT_LO])) begin
         p_num = NUM_MIN;
      end else begin
         p_num = {p1_ff[N_W-F_B-1:0], {F_B{1'b0}}};
      end
      if (p_ok && q_ok) begin
         num_sel = p_num;
         den_sel = q1_ff[D_W-1:0];
      end else begin
         num_sel = N_W'(x_ff);
         den_sel = D_W'(1);
      end
   end

   assign rhs = CMP_W'(st_num_ff) * $signed({{(N_W+1){1'b0}}, den_ff});
   assign den_scaled = $signed({{(N_W-D_W-F_B){1'b0}}, den_ff, {F_B{1'b0}}});

   always_comb begin
      if (num_ff > den_scaled) begin
         aspect_in = cfra_pkg::ASPECT_LANDSCAPE;
      end else if (num_ff < den_scaled) begin
         aspect_in = cfra_pkg::ASPECT_PORTRAIT;
      end else begin
         aspect_in = cfra_pkg::ASPECT_SQUARE;
      end
      st_num_in = st_num_ff;
      st_den_in = st_den_ff;
      if (cmd.commit) begin
         st_num_in = num_ff;
         st_den_in = den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_num_ff <= $signed(ONE_Q);
         st_den_ff <= D_W'(1);
      end else begin
         st_num_ff <= st_num_in;
         st_den_ff <= st_den_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= req_ratio_in;
         p0_ff  <= P_W'(1);
         q0_ff  <= '0;
         p1_ff  <= P_W'($signed(req_ratio_in[R_W-1:F_B]));
         q1_ff  <= Q_W'(1);
         rem_ff <= {req_ratio_in[F_B-1:0], {(cfra_pkg::REM_W-F_B){1'b0}}};
      end else if (cmd.upd) begin
         p0_ff  <= p1_ff;
         q0_ff  <= q1_ff;
         p1_ff  <= ap_ff + p0_ff;
         q1_ff  <= aq_ff + q0_ff;
         rem_ff <= quo_ff[cfra_pkg::REM_W-1:0];
      end
      if (cmd.chk_mul) begin
         prod_ff <= $signed({{(LQ_W+1){x_ff[R_W-1]}}, x_ff})
                  * $signed({{(R_W+1){1'b0}}, q1_ff[LQ_W-1:0]});
      end
      if (cmd.chk_err) begin
         err_ff     <= err_abs[E_W-1:0];
         err_big_ff <= |err_abs[DIFF_W-1:E_W];
      end
      if (cmd.div_init) begin
         part_ff <= (cfra_pkg::REM_W+1)'(1);
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         part_ff <= qbit ? part_sub : part_sh;
         quo_ff  <= {quo_ff[2*cfra_pkg::REM_W-2:0], qbit};
      end
      if (cmd.mul) begin
         ap_ff <= ap_prod[P_W-1:0];
         aq_ff <= aq_prod[Q_W-1:0];
      end
      if (cmd.fin_sel) begin
         num_ff <= num_sel;
         den_ff <= den_sel;
         fb_ff  <= !(p_ok && q_ok);
      end
      if (cmd.cmp_l) begin
         lhs_ff <= CMP_W'(num_ff) * $signed({{(N_W+1){1'b0}}, st_den_ff});
      end
      if (cmd.commit) begin
         fb_out_ff <= fb_ff;
         chg_ff    <= lhs_ff != rhs;
         aspect_ff <= aspect_in;
      end
   end

   assign rsp_frac_numerator   = st_num_ff;
   assign rsp_frac_denominator = st_den_ff;
   assign rsp_used_fallback    = fb_out_ff;
   assign rsp_ratio_changed    = chg_ff;
   assign rsp_aspect_class     = aspect_ff;

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> part_ff < {1'b0, rem_ff})
      else $error("partial remainder out of range");

endmodule

@@ hdl/continued_fraction_ratio_approx.sv @@
// Continued-fraction ratio approximator.
// Input channel req_*: one beat carries a signed Q16.16 ratio on req_ratio_in.
// Result channel rsp_*: one beat per input with numerator (Q32.16), integer
// denominator, fallback flag, changed flag against the previous fraction,
// and aspect class.
// Each term runs a stop check (states CHK_MUL, CHK_ERR, CHK_DEC), a restoring
// division of 2^64 by the remainder (one quotient bit per cycle), and a
// convergent update (states MUL, UPD). A result uses at most MAX_TERMS terms,
// and the bit-serial divider takes most of the time of each term. One item is
// in flight at a time; req_ready is high only when the sequencer is idle, in
// the cycle after the result is handed to the output register.
// A result waiting on rsp_ready is held in the output register; the next
// item is accepted and worked on meanwhile, and stalls only at its final
// step until the pending beat is taken.
// Reset (synchronous) empties the pipeline and sets the stored fraction
// to 1/1.
module continued_fraction_ratio_approx #(
   parameter int MAX_TERMS  = cfra_pkg::DEF_MAX_TERMS,
   parameter int TERM_LIMIT = cfra_pkg::DEF_TERM_LIMIT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [cfra_pkg::RATIO_W-1:0]   req_ratio_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [cfra_pkg::NUM_W-1:0]     rsp_frac_numerator,
   output logic        [cfra_pkg::DEN_W-1:0]     rsp_frac_denominator,
   output logic                                  rsp_used_fallback,
   output logic                                  rsp_ratio_changed,
   output logic        [1:0]                     rsp_aspect_class
);

   cfra_pkg::cmd_type    cmd;
   cfra_pkg::status_type status;

   cfra_ctrl #(
      .MAX_TERMS (MAX_TERMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfra_dp #(
      .TERM_LIMIT (TERM_LIMIT)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_ratio_in         (req_ratio_in),
      .rsp_frac_numerator   (rsp_frac_numerator),
      .rsp_frac_denominator (rsp_frac_denominator),
      .rsp_used_fallback    (rsp_used_fallback),
      .rsp_ratio_changed    (rsp_ratio_changed),
      .rsp_aspect_class     (rsp_aspect_class)
   );

endmodule
